[hw/rtl/mono_bmp_stream_decoder_assert.svh]
// assertion macros for the mono bmp stream decoder checker
`ifndef MONO_BMP_STREAM_DECODER_ASSERT_SVH
`define MONO_BMP_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, off while in reset
`define MBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define MBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define MBD_ASSERT_NXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mbd_pkg.sv]
// shared types and constants of the mono bmp stream decoder
`timescale 1ns / 1ps
package mbd_pkg;

  localparam int unsigned MAX_SIDE = 65535;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam logic [23:0] LOW24 = 24'hFFFFFF;

  localparam logic [5:0] HDR_SIG1      = 6'd1;
  localparam logic [5:0] HDR_WIDTH_LO  = 6'd18;
  localparam logic [5:0] HDR_HEIGHT_LO = 6'd22;
  localparam logic [5:0] HDR_PD_LO     = 6'd26;
  localparam logic [5:0] HDR_COMP_LO   = 6'd30;
  localparam logic [5:0] HDR_PAL0_LO   = 6'd54;
  localparam logic [5:0] HDR_PAL1_LO   = 6'd58;
  localparam logic [5:0] HDR_LAST      = 6'd61;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_FORMAT    = 3'd2;
  localparam logic [2:0] ERR_PALETTE   = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pixel_byte;
    logic        row_end;
    logic        image_end;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  error_code;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[hw/rtl/mbd_out_fifo.sv]
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
module mbd_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  mbd_pkg::push_t  push,
  input  logic            pop,
  output mbd_pkg::result_t head,
  output logic            not_empty,
  output logic            has_room
);

  mbd_pkg::result_t mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] wr_ptr_p1;

  assign head      = mem[rd_ptr_r];
  assign not_empty = cnt_r != 3'd0;
  assign has_room  = cnt_r < 3'd3;
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push.n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

[hw/rtl/mbd_parser.sv]
// header capture, checks and pixel row handling for each accepted byte
`timescale 1ns / 1ps
module mbd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_accept,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output mbd_pkg::push_t push
);

  typedef enum logic [1:0] {MODE_HEADER, MODE_PIXEL, MODE_DRAIN} mode_t;

  mode_t       mode_r, mode_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] pd_r, pd_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [47:0] pal_r, pal_nxt;
  logic        invert_r, invert_nxt;
  logic [13:0] cnt_r, cnt_nxt;
  logic [15:0] rows_r, rows_nxt;

  logic [5:0]  off_w, off_h, off_pd, off_c, off_p0, off_p1;
  logic [2:0]  hdr_err;
  logic        empty;
  logic [16:0] w_sum7, w_sum31;
  logic [13:0] bpr, rsz, cnt_inc;
  logic [7:0]  pix;
  logic        re, ie;
  mbd_pkg::push_t res;

  assign off_w  = idx_r - mbd_pkg::HDR_WIDTH_LO;
  assign off_h  = idx_r - mbd_pkg::HDR_HEIGHT_LO;
  assign off_pd = idx_r - mbd_pkg::HDR_PD_LO;
  assign off_c  = idx_r - mbd_pkg::HDR_COMP_LO;
  assign off_p0 = idx_r - mbd_pkg::HDR_PAL0_LO;
  assign off_p1 = idx_r - mbd_pkg::HDR_PAL1_LO;

  assign w_sum7  = {1'b0, width_r[15:0]} + 17'd7;
  assign w_sum31 = {1'b0, width_r[15:0]} + 17'd31;
  assign bpr     = w_sum7[16:3];
  assign rsz     = {w_sum31[16:5], 2'b00};
  assign cnt_inc = cnt_r + 14'd1;
  assign empty   = (width_r == 32'd0) || (height_r == 32'd0);

  always_comb begin
    if (comp_r != 32'd0) begin
      hdr_err = mbd_pkg::ERR_FORMAT;
    end else if (pd_r[15:0] != 16'd1 || pd_r[31:16] != 16'd1) begin
      hdr_err = mbd_pkg::ERR_FORMAT;
    end else if (!((pal_r[23:0] == 24'd0 && pal_r[47:24] == mbd_pkg::LOW24) ||
                   (pal_r[47:24] == 24'd0 && pal_r[23:0] == mbd_pkg::LOW24))) begin
      hdr_err = mbd_pkg::ERR_PALETTE;
    end else if (width_r > 32'(mbd_pkg::MAX_SIDE) ||
                 height_r > 32'(mbd_pkg::MAX_SIDE)) begin
      hdr_err = mbd_pkg::ERR_TOO_LARGE;
    end else begin
      hdr_err = mbd_pkg::ERR_NONE;
    end
  end

  always_comb begin
    pix = data_byte;
    re  = cnt_r == (bpr - 14'd1);
    ie  = re && (rows_r == 16'd1);
    if (invert_r) begin
      pix = ~data_byte;
      if (re && width_r[2:0] != 3'd0) begin
        pix = pix & ~(8'hFF >> width_r[2:0]);
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pd_nxt     = pd_r;
    comp_nxt   = comp_r;
    pal_nxt    = pal_r;
    invert_nxt = invert_r;
    cnt_nxt    = cnt_r;
    rows_nxt   = rows_r;
    res        = '0;

    case (mode_r)
      MODE_HEADER: begin
        if ((idx_r == 6'd0 && data_byte != mbd_pkg::SIG_B) ||
            (idx_r == mbd_pkg::HDR_SIG1 && data_byte != mbd_pkg::SIG_M)) begin
          res.n             = 2'd1;
          res.r0.kind       = mbd_pkg::KIND_ERROR;
          res.r0.error_code = mbd_pkg::ERR_SIGNATURE;
          mode_nxt          = MODE_DRAIN;
        end else begin
          if (off_w < 6'd4) begin
            width_nxt[8*off_w[1:0] +: 8] = data_byte;
          end else if (off_h < 6'd4) begin
            height_nxt[8*off_h[1:0] +: 8] = data_byte;
          end else if (off_pd < 6'd4) begin
            pd_nxt[8*off_pd[1:0] +: 8] = data_byte;
          end else if (off_c < 6'd4) begin
            comp_nxt[8*off_c[1:0] +: 8] = data_byte;
          end else if (off_p0 < 6'd3) begin
            pal_nxt[8*off_p0[1:0] +: 8] = data_byte;
          end else if (off_p1 < 6'd3) begin
            pal_nxt[24 + 8*off_p1[1:0] +: 8] = data_byte;
          end
          if (idx_r >= mbd_pkg::HDR_LAST) begin
            res.n = 2'd1;
            if (hdr_err != mbd_pkg::ERR_NONE) begin
              res.r0.kind       = mbd_pkg::KIND_ERROR;
              res.r0.error_code = hdr_err;
              mode_nxt          = MODE_DRAIN;
            end else begin
              res.r0.kind         = mbd_pkg::KIND_HEADER;
              res.r0.image_end    = empty;
              res.r0.image_width  = width_r[15:0];
              res.r0.image_height = height_r[15:0];
              invert_nxt          = pal_r[23:0] == 24'd0;
              rows_nxt            = height_r[15:0];
              cnt_nxt             = 14'd0;
              mode_nxt            = empty ? MODE_DRAIN : MODE_PIXEL;
            end
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      MODE_PIXEL: begin
        if (cnt_r < bpr) begin
          res.n             = 2'd1;
          res.r0.kind       = mbd_pkg::KIND_PIXEL;
          res.r0.pixel_byte = pix;
          res.r0.row_end    = re;
          res.r0.image_end  = ie;
          if (re) begin
            rows_nxt = rows_r - 16'd1;
          end
          if (ie) begin
            mode_nxt = MODE_DRAIN;
          end
        end
        cnt_nxt = (cnt_inc >= rsz) ? 14'd0 : cnt_inc;
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (mode_nxt == MODE_HEADER || mode_nxt == MODE_PIXEL) begin
        if (res.n == 2'd0) begin
          res.r0.kind       = mbd_pkg::KIND_ERROR;
          res.r0.error_code = mbd_pkg::ERR_TRUNCATED;
        end else begin
          res.r1.kind       = mbd_pkg::KIND_ERROR;
          res.r1.error_code = mbd_pkg::ERR_TRUNCATED;
        end
        res.n = res.n + 2'd1;
      end
      mode_nxt   = MODE_HEADER;
      idx_nxt    = 6'd0;
      width_nxt  = 32'd0;
      height_nxt = 32'd0;
      pd_nxt     = 32'd0;
      comp_nxt   = 32'd0;
      pal_nxt    = 48'd0;
      invert_nxt = 1'b0;
      cnt_nxt    = 14'd0;
      rows_nxt   = 16'd0;
    end
  end

  always_comb begin
    push = res;
    if (!in_accept) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HEADER;
      idx_r    <= 6'd0;
      width_r  <= 32'd0;
      height_r <= 32'd0;
      pd_r     <= 32'd0;
      comp_r   <= 32'd0;
      pal_r    <= 48'd0;
      invert_r <= 1'b0;
      cnt_r    <= 14'd0;
      rows_r   <= 16'd0;
    end else if (in_accept) begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pd_r     <= pd_nxt;
      comp_r   <= comp_nxt;
      pal_r    <= pal_nxt;
      invert_r <= invert_nxt;
      cnt_r    <= cnt_nxt;
      rows_r   <= rows_nxt;
    end
  end

endmodule

[hw/rtl/mono_bmp_stream_decoder.sv]
// top level of the mono bmp stream decoder
// usage:
//   in_* carries the bmp file one byte per beat, in_tlast on its final byte
//   out_* carries results: out_tuser is the kind (pixel, header, error),
//   out_tlast flags the end of an image: its last pixel byte, or the header of an empty one
//   a file starts with 'B','M' and a 60 byte header; once the header checks
//   out, one header beat gives width and height, then each row's data bytes
//   follow with padding dropped and pixels normalized so 1 means black
//   a bad file gives one error beat and is then skipped up to in_tlast
// timing:
//   results of a byte show on out_* the cycle after it is taken when nothing
//   waits ahead of them; a second result of the same byte queues behind the first
//   one input byte per cycle sustained; in_tready drops only while three or
//   more results sit in the four entry result queue, which only a receiver
//   stall brings about; the stall holds the head beat, fills the queue and
//   then backs up the input
// reset:
//   rst_n low clears the queue and returns the parser to the start of a
//   file; the parser also returns there after every taken beat with in_tlast set
`timescale 1ns / 1ps
module mono_bmp_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_byte, row_end, image_width, image_height, error_code
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  logic             in_accept;
  logic             has_room;
  mbd_pkg::push_t   push;
  mbd_pkg::result_t head;

  assign in_tready = has_room;
  assign in_accept = in_tvalid && has_room;

  mbd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  mbd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tvalid && out_tready),
    .head      (head),
    .not_empty (out_tvalid),
    .has_room  (has_room)
  );

  assign out_tdata = {4'b0000, head.error_code, head.image_height, head.image_width,
                      head.row_end, head.pixel_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.image_end;

endmodule

[hw/rtl/mbd_checker.sv]
// port checker for the mono bmp stream decoder, bound to the top level
`timescale 1ns / 1ps
`include "mono_bmp_stream_decoder_assert.svh"
module mbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `MBD_ASSERT_NXT_ANY(a_reset_empty, !rst_n, !out_tvalid, "output valid right after reset")
  `MBD_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled beat changed")
  `MBD_ASSERT_IMP(a_header_clean, out_tvalid && out_tuser == mbd_pkg::KIND_HEADER, out_tdata[7:0] == 8'd0 && out_tdata[43:41] == mbd_pkg::ERR_NONE, "header beat carries pixel or error bits")
  `MBD_ASSERT_IMP(a_error_code, out_tvalid && out_tuser == mbd_pkg::KIND_ERROR, !out_tlast && out_tdata[43:41] != mbd_pkg::ERR_NONE, "error beat without a code")

endmodule

bind mono_bmp_stream_decoder mbd_checker u_mbd_checker (.*);

[tb/sv/mono_bmp_result_checker.sv]
// result checker for the mono bmp stream decoder: predicts and compares beats
`timescale 1ns / 1ps
module mono_bmp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // pixel_byte, row_end, image_width, image_height, error_code
  input  logic [1:0]  out_tuser,  // kind
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {IN_HEADER, IN_PIXELS, SKIPPING} parse_state_t;

  parse_state_t parse_state;
  logic [5:0]   hdr_pos;
  logic [31:0]  width_cap;
  logic [31:0]  height_cap;
  logic [31:0]  planes_bits_cap;
  logic [31:0]  comp_cap;
  logic [23:0]  color0_cap;
  logic [23:0]  color1_cap;
  logic         invert;
  logic [13:0]  row_pos;
  logic [15:0]  rows_left;

  mbd_pkg::result_t expected_q[$];
  mbd_pkg::result_t want;

  function automatic void clear_parser();
    parse_state     = IN_HEADER;
    hdr_pos         = '0;
    width_cap       = '0;
    height_cap      = '0;
    planes_bits_cap = '0;
    comp_cap        = '0;
    color0_cap      = '0;
    color1_cap      = '0;
    invert          = 1'b0;
    row_pos         = '0;
    rows_left       = '0;
  endfunction

  function automatic void expect_beat(logic [1:0] kind, logic [7:0] pix, logic re, logic ie,
                                      logic [15:0] w, logic [15:0] h, logic [2:0] err);
    mbd_pkg::result_t r;
    r.kind         = kind;
    r.pixel_byte   = pix;
    r.row_end      = re;
    r.image_end    = ie;
    r.image_width  = w;
    r.image_height = h;
    r.error_code   = err;
    expected_q.push_back(r);
  endfunction

  function automatic logic [2:0] header_fault();
    if (comp_cap != 0) return mbd_pkg::ERR_FORMAT;
    if (planes_bits_cap[15:0] != 16'd1) return mbd_pkg::ERR_FORMAT;
    if (planes_bits_cap[31:16] != 16'd1) return mbd_pkg::ERR_FORMAT;
    if (!((color0_cap == 24'h0 && color1_cap == mbd_pkg::LOW24) ||
          (color1_cap == 24'h0 && color0_cap == mbd_pkg::LOW24)))
      return mbd_pkg::ERR_PALETTE;
    if (width_cap > mbd_pkg::MAX_SIDE || height_cap > mbd_pkg::MAX_SIDE)
      return mbd_pkg::ERR_TOO_LARGE;
    return mbd_pkg::ERR_NONE;
  endfunction

  function automatic void capture_header(int pos, logic [7:0] b);
    if (pos >= mbd_pkg::HDR_WIDTH_LO && pos < mbd_pkg::HDR_WIDTH_LO + 4)
      width_cap[8 * (pos - mbd_pkg::HDR_WIDTH_LO) +: 8] = b;
    else if (pos >= mbd_pkg::HDR_HEIGHT_LO && pos < mbd_pkg::HDR_HEIGHT_LO + 4)
      height_cap[8 * (pos - mbd_pkg::HDR_HEIGHT_LO) +: 8] = b;
    else if (pos >= mbd_pkg::HDR_PD_LO && pos < mbd_pkg::HDR_PD_LO + 4)
      planes_bits_cap[8 * (pos - mbd_pkg::HDR_PD_LO) +: 8] = b;
    else if (pos >= mbd_pkg::HDR_COMP_LO && pos < mbd_pkg::HDR_COMP_LO + 4)
      comp_cap[8 * (pos - mbd_pkg::HDR_COMP_LO) +: 8] = b;
    else if (pos >= mbd_pkg::HDR_PAL0_LO && pos < mbd_pkg::HDR_PAL0_LO + 3)
      color0_cap[8 * (pos - mbd_pkg::HDR_PAL0_LO) +: 8] = b;
    else if (pos >= mbd_pkg::HDR_PAL1_LO && pos < mbd_pkg::HDR_PAL1_LO + 3)
      color1_cap[8 * (pos - mbd_pkg::HDR_PAL1_LO) +: 8] = b;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    int          pos;
    logic [2:0]  fault;
    logic        empty;
    int unsigned row_data_bytes;
    int unsigned padded_row;
    int unsigned col;
    logic [7:0]  pix;
    logic        row_done;
    logic        image_done;
    pos = int'(hdr_pos);
    if (parse_state == IN_HEADER) begin
      if ((pos == 0 && b != mbd_pkg::SIG_B) ||
          (pos == mbd_pkg::HDR_SIG1 && b != mbd_pkg::SIG_M)) begin
        expect_beat(mbd_pkg::KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0, 16'h0,
                    mbd_pkg::ERR_SIGNATURE);
        parse_state = SKIPPING;
      end else begin
        capture_header(pos, b);
        if (pos >= mbd_pkg::HDR_LAST) begin
          fault = header_fault();
          if (fault != mbd_pkg::ERR_NONE) begin
            expect_beat(mbd_pkg::KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0, 16'h0, fault);
            parse_state = SKIPPING;
          end else begin
            empty = (width_cap == 0) || (height_cap == 0);
            expect_beat(mbd_pkg::KIND_HEADER, 8'h0, 1'b0, empty, width_cap[15:0],
                        height_cap[15:0], mbd_pkg::ERR_NONE);
            invert      = (color0_cap == 24'h0);
            rows_left   = height_cap[15:0];
            row_pos     = '0;
            parse_state = empty ? SKIPPING : IN_PIXELS;
          end
        end else begin
          hdr_pos = hdr_pos + 6'd1;
        end
      end
    end else if (parse_state == IN_PIXELS) begin
      row_data_bytes = (width_cap + 7) >> 3;
      padded_row     = ((width_cap + 31) >> 5) << 2;
      col            = 32'(row_pos);
      if (col < row_data_bytes) begin
        pix        = b;
        row_done   = (col == row_data_bytes - 1);
        image_done = 1'b0;
        if (invert) begin
          pix = ~pix;
          if (row_done && width_cap[2:0] != 3'd0)
            pix = pix & ~(8'hFF >> width_cap[2:0]);
        end
        if (row_done) begin
          rows_left  = rows_left - 16'd1;
          image_done = (rows_left == 16'd0);
        end
        expect_beat(mbd_pkg::KIND_PIXEL, pix, row_done, image_done, 16'h0, 16'h0,
                    mbd_pkg::ERR_NONE);
        if (image_done) parse_state = SKIPPING;
      end
      col = col + 1;
      if (col >= padded_row) col = 0;
      row_pos = col[13:0];
    end
    if (last) begin
      if (parse_state != SKIPPING)
        expect_beat(mbd_pkg::KIND_ERROR, 8'h0, 1'b0, 1'b0, 16'h0, 16'h0,
                    mbd_pkg::ERR_TRUNCATED);
      clear_parser();
    end
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      clear_parser();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected beat kind %0d data %0h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("pixel_byte", 32'(want.pixel_byte), 32'(out_tdata[7:0]));
          check_field("row_end", 32'(want.row_end), 32'(out_tdata[8]));
          check_field("image_end", 32'(want.image_end), 32'(out_tlast));
          check_field("image_width", 32'(want.image_width), 32'(out_tdata[24:9]));
          check_field("image_height", 32'(want.image_height), 32'(out_tdata[40:25]));
          check_field("error_code", 32'(want.error_code), 32'(out_tdata[43:41]));
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    pending <= expected_q.size();
  end

endmodule

[tb/sv/tb_mono_bmp_stream_decoder.sv]
// testbench top for the mono bmp stream decoder: file stimulus and verdict
`timescale 1ns / 1ps
module tb_mono_bmp_stream_decoder;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_BUDGET   = 1350;
  localparam logic [23:0] BLACK = 24'h000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int file_count   = 0;
  int sent_bytes   = 0;
  logic [7:0] file_bytes[$];

  always #2 clk = ~clk;

  mono_bmp_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  mono_bmp_result_checker result_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic next_phase();
    case (file_count % 4)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 69;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 69;
      end
      default: begin
        idle_pct  = 11;
        stall_pct = 11;
      end
    endcase
    file_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  // cut > 0 and below the file's size ends the file early after that many bytes
  task automatic send_file(input int cut);
    int n;
    n = file_bytes.size();
    if (cut > 0 && cut < n) n = cut;
    next_phase();
    for (int i = 0; i < n; i++) push_byte(file_bytes[i], i == n - 1);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic put_random(input int nbytes);
    repeat (nbytes) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_header(input logic [31:0] w, input logic [31:0] h,
                              input logic [15:0] planes, input logic [15:0] bits,
                              input logic [31:0] comp, input logic [23:0] c0,
                              input logic [23:0] c1);
    file_bytes.delete();
    file_bytes.push_back(mbd_pkg::SIG_B);
    file_bytes.push_back(mbd_pkg::SIG_M);
    put_random(16);
    put_le(w, 4);
    put_le(h, 4);
    put_le(planes, 2);
    put_le(bits, 2);
    put_le(comp, 4);
    put_random(20);
    put_le(c0, 3);
    put_random(1);
    put_le(c1, 3);
    put_random(1);
  endtask

  task automatic add_rows(input int unsigned w, input int unsigned rows);
    put_random(rows * (((w + 31) >> 5) << 2));
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned sel;
    int unsigned pad;
    logic [23:0] c0;
    logic [23:0] c1;
    int cut;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // signature faults and a file cut after its first byte
    file_bytes = '{8'h00};
    send_file(0);
    file_bytes = '{mbd_pkg::SIG_B, 8'hFF, mbd_pkg::SIG_B};
    send_file(0);
    file_bytes = '{mbd_pkg::SIG_B};
    send_file(0);

    // good images, both palette orders, margin clearing, short padding, trailing bytes
    build_header(8, 1, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    add_rows(8, 1);
    send_file(0);
    build_header(13, 2, 1, 1, 0, mbd_pkg::LOW24, BLACK);
    add_rows(13, 2);
    put_random(3);
    send_file(0);
    build_header(13, 3, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    add_rows(13, 3);
    repeat (2) void'(file_bytes.pop_back());
    send_file(0);

    // header faults
    build_header(8, 1, 1, 1, 1, BLACK, mbd_pkg::LOW24);
    send_file(0);
    build_header(8, 1, 2, 1, 0, BLACK, mbd_pkg::LOW24);
    send_file(0);
    build_header(8, 1, 1, 8, 0, BLACK, mbd_pkg::LOW24);
    send_file(0);
    build_header(8, 1, 1, 1, 0, mbd_pkg::LOW24, mbd_pkg::LOW24);
    send_file(0);
    build_header(65536, 1, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    send_file(0);
    build_header(1, 32'hFFFF_FFFF, 1, 1, 0, mbd_pkg::LOW24, BLACK);
    add_rows(1, 1);
    send_file(0);

    // empty images and the largest accepted size
    build_header(65535, 0, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    put_random(2);
    send_file(0);
    build_header(0, 65535, 1, 1, 0, mbd_pkg::LOW24, BLACK);
    send_file(0);
    build_header(65535, 65535, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    put_random(2);
    send_file(0);

    // early ends: in the header, in row data, in row padding
    build_header(8, 1, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    send_file(40);
    build_header(20, 2, 1, 1, 0, BLACK, mbd_pkg::LOW24);
    add_rows(20, 2);
    send_file(63);
    build_header(20, 2, 1, 1, 0, mbd_pkg::LOW24, BLACK);
    add_rows(20, 2);
    send_file(66);

    wait_results_drained();

    while (sent_bytes < ITEM_BUDGET) begin
      sel = $urandom_range(99);
      w   = $urandom_range(64, 1);
      h   = $urandom_range(4, 1);
      if ($urandom_range(1)) begin
        c0 = BLACK;
        c1 = mbd_pkg::LOW24;
      end else begin
        c0 = mbd_pkg::LOW24;
        c1 = BLACK;
      end
      cut = 0;
      if (sel < 75) begin
        build_header(w, h, 1, 1, 0, c0, c1);
        add_rows(w, h);
        case ($urandom_range(9))
          0: begin
            pad = (((w + 31) >> 5) << 2) - ((w + 7) >> 3);
            if (pad > 0) repeat ($urandom_range(pad, 1)) void'(file_bytes.pop_back());
          end
          1: put_random($urandom_range(4, 1));
          2: cut = $urandom_range(file_bytes.size(), 1);
          default: ;
        endcase
      end else if (sel < 80) begin
        if ($urandom_range(1)) build_header(0, $urandom_range(65535), 1, 1, 0, c0, c1);
        else build_header($urandom_range(65535), 0, 1, 1, 0, c0, c1);
        put_random($urandom_range(3));
      end else if (sel < 92) begin
        case ($urandom_range(5))
          0: build_header(w, h, 1, 1, $urandom_range(32'hFFFF_FFFF, 1), c0, c1);
          1: build_header(w, h, 16'($urandom_range(65535)), 1, 0, c0, c1);
          2: build_header(w, h, 1, 16'($urandom_range(65535)), 0, c0, c1);
          3: build_header(w, h, 1, 1, 0, 24'($urandom_range(24'hFFFFFF)),
                          24'($urandom_range(24'hFFFFFF)));
          4: build_header($urandom_range(32'hFFFF_FFFF, 65536), h, 1, 1, 0, c0, c1);
          default: build_header(w, $urandom_range(32'hFFFF_FFFF, 65536), 1, 1, 0, c0, c1);
        endcase
        put_random($urandom_range(3));
        if ($urandom_range(3) == 0) file_bytes[$urandom_range(1)] = 8'($urandom_range(255));
      end else begin
        file_bytes.delete();
        put_random($urandom_range(6, 1));
      end
      send_file(cut);
      if (file_count % 6 == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[mono_bmp_stream_decoder.f]
+incdir+hw/rtl
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_out_fifo.sv
hw/rtl/mbd_parser.sv
hw/rtl/mono_bmp_stream_decoder.sv
hw/rtl/mbd_checker.sv
tb/sv/mono_bmp_result_checker.sv
tb/sv/tb_mono_bmp_stream_decoder.sv
